// File: hdl/cpu_alu_8_16_with_flags_defines.svh
// ----------------------------------------------------------------------------
// cpu_alu_8_16_with_flags_defines.svh
// Assertion macros shared by the ALU RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_8_16_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_8_16_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define CALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define CALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg
// Operation codes and flag type for the 8/16-bit ALU.
// ----------------------------------------------------------------------------
package calu_pkg;

    localparam int unsigned DATA_W = 16;

    typedef enum logic [4:0] {
        KIND_ADC        = 5'd0,
        KIND_SBC        = 5'd1,
        KIND_AND        = 5'd2,
        KIND_EOR        = 5'd3,
        KIND_ORA        = 5'd4,
        KIND_TSB        = 5'd5,
        KIND_TRB        = 5'd6,
        KIND_ASL_A      = 5'd7,
        KIND_ASL_M      = 5'd8,
        KIND_LSR_A      = 5'd9,
        KIND_LSR_M      = 5'd10,
        KIND_ROL_A      = 5'd11,
        KIND_ROL_M      = 5'd12,
        KIND_ROR_A      = 5'd13,
        KIND_ROR_M      = 5'd14,
        KIND_BIT        = 5'd15,
        KIND_CMP        = 5'd16,
        KIND_CPX        = 5'd17,
        KIND_CPY        = 5'd18,
        KIND_DEC_A      = 5'd19,
        KIND_DEX        = 5'd20,
        KIND_DEY        = 5'd21,
        KIND_DEC_M      = 5'd22,
        KIND_INC_A      = 5'd23,
        KIND_INX        = 5'd24,
        KIND_INY        = 5'd25,
        KIND_INC_M      = 5'd26,
        KIND_XBA        = 5'd27,
        KIND_LOAD_A     = 5'd28,
        KIND_LOAD_X     = 5'd29,
        KIND_LOAD_Y     = 5'd30,
        KIND_LOAD_FLAGS = 5'd31
    } kind_t;

    typedef struct packed {
        logic n;
        logic v;
        logic z;
        logic c;
    } flags_t;

endpackage

// File: hdl/calu_ifs.sv
// ----------------------------------------------------------------------------
// calu_ifs
// Valid/ready channels for ALU operations and ALU results.
// ----------------------------------------------------------------------------
interface calu_op_if;
    logic                              valid;
    logic                              ready;
    calu_pkg::kind_t                   kind;
    logic                              wide;
    logic [calu_pkg::DATA_W-1:0]       operand;

    modport source (output valid, output kind, output wide, output operand, input ready);
    modport sink   (input valid, input kind, input wide, input operand, output ready);
endinterface

interface calu_res_if;
    logic                              valid;
    logic                              ready;
    logic [calu_pkg::DATA_W-1:0]       value;
    logic                              flag_n;
    logic                              flag_v;
    logic                              flag_z;
    logic                              flag_c;

    modport source (output valid, output value, output flag_n, output flag_v,
                    output flag_z, output flag_c, input ready);
    modport sink   (input valid, input value, input flag_n, input flag_v,
                    input flag_z, input flag_c, output ready);
endinterface

// File: hdl/cpu_alu_8_16_with_flags.sv
// An operation transfer is held in the operation register, then executes into the result register.
// Throughput: 1 operation per cycle while the result is taken each cycle; the single
//   adder/logic pass between the operation register and the result register sets that figure.
// A stalled result holds in the result register while one more operation waits
//   in the operation register.
// Reset (rst_n low, asynchronous): A, X, Y and the N, V, Z, C flags clear.
// ----------------------------------------------------------------------------
// cpu_alu_8_16_with_flags
// 65816-style binary ALU with accumulator, X, Y and N/V/Z/C flags. Each
// operation works at 8 or 16 bits and returns the value plus the flags.
// ----------------------------------------------------------------------------
`include "cpu_alu_8_16_with_flags_defines.svh"

module cpu_alu_8_16_with_flags
(
    input  logic       clk,
    input  logic       rst_n,
    calu_op_if.sink    operation,
    calu_res_if.source result
);

    localparam int unsigned W = calu_pkg::DATA_W;

    // Architectural state
    logic [W-1:0]     acc_reg, x_reg, y_reg;
    calu_pkg::flags_t flags_reg;
    logic [W-1:0]     acc_next, x_next, y_next;
    calu_pkg::flags_t flags_next;

    // Operation register
    logic             in_valid_reg;
    calu_pkg::kind_t  kind_reg;
    logic             wide_reg;
    logic [W-1:0]     operand_reg;

    // Result register
    logic             out_valid_reg;
    logic [W-1:0]     value_reg;
    calu_pkg::flags_t out_flags_reg;
    logic [W-1:0]     value_next;

    logic             advance;
    logic             in_ready;

    // Datapath temporaries
    logic [W-1:0]     mask, msb, a, m, b, r, sel, dif;
    logic [W:0]       sum;
    logic             carry_out;

    // ------------------------------------------------------------------
    // Handshake: the operation register executes when the result
    // register is empty or is being drained in the same cycle.
    // ------------------------------------------------------------------
    assign advance         = in_valid_reg && (!out_valid_reg || result.ready);
    assign in_ready        = !in_valid_reg || advance;
    assign operation.ready = in_ready;

    assign result.valid  = out_valid_reg;
    assign result.value  = value_reg;
    assign result.flag_n = out_flags_reg.n;
    assign result.flag_v = out_flags_reg.v;
    assign result.flag_z = out_flags_reg.z;
    assign result.flag_c = out_flags_reg.c;

    // ------------------------------------------------------------------
    // Single-pass execute
    // ------------------------------------------------------------------
    always_comb
    begin
        // Width select: 8-bit operations touch the low byte only.
        mask = wide_reg ? 16'hFFFF : 16'h00FF;
        msb  = wide_reg ? 16'h8000 : 16'h0080;
        a    = acc_reg & mask;
        m    = operand_reg & mask;

        // Shared adder for ADC/SBC; SBC adds the inverted operand.
        b         = (kind_reg == calu_pkg::KIND_SBC) ? (~m & mask) : m;
        sum       = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, flags_reg.c};
        carry_out = wide_reg ? sum[W] : sum[8];

        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        flags_next = flags_reg;
        value_next = '0;
        r          = '0;
        sel        = '0;
        dif        = '0;

        unique case (kind_reg) inside
            calu_pkg::KIND_ADC, calu_pkg::KIND_SBC:
            begin
                r            = sum[W-1:0] & mask;
                flags_next.c = carry_out;
                flags_next.v = |(~(a ^ b) & (a ^ r) & msb);
                flags_next.n = |(r & msb);
                flags_next.z = (r == '0);
                acc_next     = (acc_reg & ~mask) | r;
                value_next   = acc_next;
            end
            calu_pkg::KIND_AND, calu_pkg::KIND_EOR, calu_pkg::KIND_ORA:
            begin
                case (kind_reg)
                    calu_pkg::KIND_AND: r = a & m;
                    calu_pkg::KIND_EOR: r = a ^ m;
                    default:            r = a | m;
                endcase
                flags_next.n = |(r & msb);
                flags_next.z = (r == '0);
                acc_next     = (acc_reg & ~mask) | r;
                value_next   = acc_next;
            end
            calu_pkg::KIND_TSB, calu_pkg::KIND_TRB:
            begin
                flags_next.z = ((a & m) == '0);
                value_next   = (kind_reg == calu_pkg::KIND_TSB) ? (m | a) : (m & ~a & mask);
            end
            calu_pkg::KIND_ASL_A, calu_pkg::KIND_ASL_M, calu_pkg::KIND_LSR_A,
            calu_pkg::KIND_LSR_M, calu_pkg::KIND_ROL_A, calu_pkg::KIND_ROL_M,
            calu_pkg::KIND_ROR_A, calu_pkg::KIND_ROR_M:
            begin
                // Odd codes act on A, even codes on the operand.
                sel = kind_reg[0] ? a : m;
                case (kind_reg) inside
                    calu_pkg::KIND_ASL_A, calu_pkg::KIND_ASL_M:
                    begin
                        r            = (sel << 1) & mask;
                        flags_next.c = |(sel & msb);
                    end
                    calu_pkg::KIND_ROL_A, calu_pkg::KIND_ROL_M:
                    begin
                        r            = ((sel << 1) | {{(W-1){1'b0}}, flags_reg.c}) & mask;
                        flags_next.c = |(sel & msb);
                    end
                    calu_pkg::KIND_LSR_A, calu_pkg::KIND_LSR_M:
                    begin
                        r            = sel >> 1;
                        flags_next.c = sel[0];
                    end
                    default:
                    begin
                        r            = (sel >> 1) | (flags_reg.c ? msb : '0);
                        flags_next.c = sel[0];
                    end
                endcase
                flags_next.n = |(r & msb);
                flags_next.z = (r == '0);
                if (kind_reg[0])
                begin
                    acc_next   = (acc_reg & ~mask) | r;
                    value_next = acc_next;
                end
                else
                begin
                    value_next = r;
                end
            end
            calu_pkg::KIND_BIT:
            begin
                r            = a & m;
                flags_next.n = |(m & msb);
                flags_next.v = wide_reg ? m[14] : m[6];
                flags_next.z = (r == '0);
                value_next   = r;
            end
            calu_pkg::KIND_CMP, calu_pkg::KIND_CPX, calu_pkg::KIND_CPY:
            begin
                case (kind_reg)
                    calu_pkg::KIND_CMP: sel = a;
                    calu_pkg::KIND_CPX: sel = x_reg & mask;
                    default:            sel = y_reg & mask;
                endcase
                dif          = sel - m;
                r            = dif & mask;
                flags_next.c = (sel >= m);
                flags_next.n = |(r & msb);
                flags_next.z = (r == '0);
                value_next   = r;
            end
            calu_pkg::KIND_DEC_A, calu_pkg::KIND_DEX, calu_pkg::KIND_DEY,
            calu_pkg::KIND_DEC_M, calu_pkg::KIND_INC_A, calu_pkg::KIND_INX,
            calu_pkg::KIND_INY, calu_pkg::KIND_INC_M:
            begin
                case (kind_reg) inside
                    calu_pkg::KIND_DEC_A, calu_pkg::KIND_INC_A: sel = a;
                    calu_pkg::KIND_DEX, calu_pkg::KIND_INX:     sel = x_reg & mask;
                    calu_pkg::KIND_DEY, calu_pkg::KIND_INY:     sel = y_reg & mask;
                    default:                                    sel = m;
                endcase
                if (kind_reg >= calu_pkg::KIND_INC_A)
                    dif = sel + 16'd1;
                else
                    dif = sel - 16'd1;
                r            = dif & mask;
                flags_next.n = |(r & msb);
                flags_next.z = (r == '0);
                case (kind_reg) inside
                    calu_pkg::KIND_DEC_A, calu_pkg::KIND_INC_A:
                    begin
                        acc_next   = (acc_reg & ~mask) | r;
                        value_next = acc_next;
                    end
                    calu_pkg::KIND_DEX, calu_pkg::KIND_INX:
                    begin
                        x_next     = (x_reg & ~mask) | r;
                        value_next = x_next;
                    end
                    calu_pkg::KIND_DEY, calu_pkg::KIND_INY:
                    begin
                        y_next     = (y_reg & ~mask) | r;
                        value_next = y_next;
                    end
                    default:
                    begin
                        value_next = r;
                    end
                endcase
            end
            calu_pkg::KIND_XBA:
            begin
                // Full 16-bit swap; flags follow the new low byte.
                acc_next     = {acc_reg[7:0], acc_reg[15:8]};
                flags_next.n = acc_reg[15];
                flags_next.z = (acc_reg[15:8] == 8'd0);
                value_next   = acc_next;
            end
            calu_pkg::KIND_LOAD_A, calu_pkg::KIND_LOAD_X, calu_pkg::KIND_LOAD_Y:
            begin
                flags_next.n = |(m & msb);
                flags_next.z = (m == '0);
                case (kind_reg)
                    calu_pkg::KIND_LOAD_A:
                    begin
                        acc_next   = (acc_reg & ~mask) | m;
                        value_next = acc_next;
                    end
                    calu_pkg::KIND_LOAD_X:
                    begin
                        x_next     = (x_reg & ~mask) | m;
                        value_next = x_next;
                    end
                    default:
                    begin
                        y_next     = (y_reg & ~mask) | m;
                        value_next = y_next;
                    end
                endcase
            end
            default:
            begin
                // Flag load: operand bits 3..0 are n, v, z, c.
                flags_next = calu_pkg::flags_t'(operand_reg[3:0]);
                value_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            // Accept a new transfer whenever the operation register frees up.
            if (in_ready)
                in_valid_reg <= operation.valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            // Commit architectural state only when the operation executes.
            if (advance)
            begin
                acc_reg   <= acc_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                flags_reg <= flags_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_ready && operation.valid)
        begin
            kind_reg    <= operation.kind;
            wide_reg    <= operation.wide;
            operand_reg <= operation.operand;
        end
        if (advance)
        begin
            value_reg     <= value_next;
            out_flags_reg <= flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CALU_ASSERT_NEXT(a_state_holds_when_idle, !advance,
        $stable(acc_reg) && $stable(x_reg) && $stable(y_reg) && $stable(flags_reg),
        "register file changed without an executing operation")

    `CALU_ASSERT_NEXT(a_result_follows_execute, advance, out_valid_reg,
        "executed operation produced no result")

    `CALU_ASSERT_NEXT(a_narrow_keeps_high_byte,
        advance && !wide_reg && (kind_reg != calu_pkg::KIND_XBA),
        acc_reg[15:8] == $past(acc_reg[15:8]),
        "8-bit operation changed accumulator high byte")

    `CALU_ASSERT_NEXT(a_compare_no_write,
        advance && ((kind_reg == calu_pkg::KIND_CMP) || (kind_reg == calu_pkg::KIND_CPX)
                    || (kind_reg == calu_pkg::KIND_CPY)),
        $stable(acc_reg) && $stable(x_reg) && $stable(y_reg) && (flags_reg.v == $past(flags_reg.v)),
        "compare wrote a register or V")

    `CALU_ASSERT_NOW(a_result_flags_match_state, out_valid_reg && !in_valid_reg,
        out_flags_reg == flags_reg,
        "reported flags differ from committed flags")

endmodule
